// ----- sv/chained_xor_decrypt_text_filter_macros.svh -----
// Assertion macros for the chained XOR decrypt text filter.
`ifndef CHAINED_XOR_DECRYPT_TEXT_FILTER_MACROS_SVH
`define CHAINED_XOR_DECRYPT_TEXT_FILTER_MACROS_SVH

// Property must hold on every clock edge out of reset.
`define CXDTF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true out of reset.
`define CXDTF_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- sv/cxdtf_pkg.sv -----
// Shared constants, types and lookup functions for the decrypt text filter.
package cxdtf_pkg;

  localparam int WINDOW_BYTES = 64;
  localparam int CHECK_BYTES  = 12;

  localparam int POS_W  = $clog2(WINDOW_BYTES);
  localparam int LEN_W  = $clog2(WINDOW_BYTES + 1);
  localparam int CNT_W  = 4;
  localparam int PCT_W  = 7;
  localparam int PROD_W = 12;

  localparam int KEY_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int DATA_W    = 24;
  localparam int USER_W    = 2;

  localparam int IDX_OUT_W = 6;
  localparam int LEN_OUT_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_KEY       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CYR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOWEL_LO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOWEL_HI  = 3'd4;

  localparam logic [CNT_W-1:0] MIN_RUN_RST  = 4'd5;
  localparam logic [CNT_W-1:0] MIN_CYR_RST  = 4'd3;
  localparam logic [PCT_W-1:0] VOWEL_LO_RST = 7'd20;
  localparam logic [PCT_W-1:0] VOWEL_HI_RST = 7'd65;

  localparam logic [PROD_W-1:0] PCT_SCALE = 12'd100;
  localparam logic [LEN_OUT_W-1:0] LEN_MAX = 7'd127;

  typedef struct packed {
    logic load_in;
    logic step;
  } cmd_t;

  function automatic logic is_cyrillic(input logic [7:0] b);
    return (b >= 8'hc0) && (b != 8'hff);
  endfunction

  function automatic logic is_allowed(input logic [7:0] b);
    return is_cyrillic(b) || ((b >= 8'h20) && (b < 8'h7f));
  endfunction

  function automatic logic vowel_letter(input logic [7:0] b);
    logic r;
    case (b)
      8'hc1, 8'hc5, 8'hc9, 8'hcf, 8'hd5, 8'hd9, 8'hc0, 8'hd1, 8'hc7,
      8'he1, 8'he5, 8'he9, 8'hef, 8'hf5, 8'hf9, 8'he0, 8'hf1, 8'he7,
      8'ha3, 8'hb3: r = 1'b1;
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_bigram(input logic [15:0] p);
    logic r;
    case (p)
      16'hd4d3, 16'hcfd4, 16'hd8d4, 16'hc1ce, 16'hc1d2, 16'hcfd0, 16'hd2d0,
      16'hd7cf, 16'hc7cf, 16'hced1, 16'hcbd3, 16'hd4c1, 16'hdec1, 16'hd2c5,
      16'hc1d7, 16'hc9cc, 16'hcfce, 16'hc5ce, 16'hcdcf, 16'hc5cd, 16'hd0cf,
      16'hcbcf, 16'hc5cb, 16'hc1cc, 16'hcdce, 16'hcec5, 16'hc1cd, 16'hcfcd,
      16'hd1cd, 16'hefd4, 16'hefd1, 16'heed5, 16'hefce, 16'hf3cf, 16'hf2c1,
      16'hf4cf, 16'hc1d4, 16'hc9d3, 16'hcfd2, 16'hd0d2: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/cxdtf_ctrl.sv -----
// Controller: input and output handshakes and sequencing of the decode step.
module cxdtf_ctrl
  import cxdtf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_WAIT = 2'b01,
    S_STEP = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  always_comb begin
    state_next  = state;
    cmd.load_in = 1'b0;
    cmd.step    = 1'b0;
    s_tready    = 1'b0;
    unique case (state)
      S_WAIT: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
        if (s_tvalid) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        // output register free or draining this cycle
        cmd.step = !out_valid || m_tready;
        if (cmd.step) begin
          state_next = S_WAIT;
        end
      end
      default: state_next = S_WAIT;
    endcase
  end

  always_comb begin
    out_valid_next = (out_valid && !m_tready) || cmd.step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WAIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

endmodule

// ----- sv/cxdtf_dp.sv -----
// Datapath: registers, chained XOR decode, window statistics and verdict.
module cxdtf_dp
  import cxdtf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic [7:0]           in_cipher,
  input  logic                 in_start,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  output logic [7:0]           out_plain,
  output logic [IDX_OUT_W-1:0] out_index,
  output logic                 out_text,
  output logic                 out_done,
  output logic                 out_hit,
  output logic [LEN_OUT_W-1:0] out_len
);

  logic [KEY_W-1:0] key_value;
  logic [CNT_W-1:0] min_run, min_cyrillic;
  logic [PCT_W-1:0] vowel_low_pct, vowel_high_pct;

  logic [7:0] cipher_reg;
  logic       start_reg;

  logic [POS_W-1:0] position, position_next;
  logic [7:0]       previous_plain, previous_plain_next;
  logic             terminated, terminated_next;
  logic             rejected, rejected_next;
  logic [CNT_W-1:0] check_run, check_run_next;
  logic [CNT_W-1:0] vowel_count, vowel_count_next;
  logic [CNT_W-1:0] cyrillic_count, cyrillic_count_next;
  logic             bigram_seen, bigram_seen_next;
  logic [LEN_W-1:0] length_so_far, length_so_far_next;

  logic [POS_W-1:0] pos_c;
  logic [7:0]       prev_c, key_byte, tmp, v, plain_c;
  logic             term_c, rej_c, big_c, in_check, text_c, done_c, hit_c;
  logic [CNT_W-1:0] run_c, vow_c, cyr_c;
  logic [LEN_W-1:0] len_c;
  logic [PROD_W-1:0] vowel_scaled, low_bound, high_bound;
  logic [LEN_OUT_W-1:0] len_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_value      <= '0;
      min_run        <= MIN_RUN_RST;
      min_cyrillic   <= MIN_CYR_RST;
      vowel_low_pct  <= VOWEL_LO_RST;
      vowel_high_pct <= VOWEL_HI_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY:      key_value      <= cfg_data;
        REG_MIN_RUN:  min_run        <= cfg_data[CNT_W-1:0];
        REG_MIN_CYR:  min_cyrillic   <= cfg_data[CNT_W-1:0];
        REG_VOWEL_LO: vowel_low_pct  <= cfg_data[PCT_W-1:0];
        REG_VOWEL_HI: vowel_high_pct <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cipher_reg <= in_cipher;
      start_reg  <= in_start;
    end
  end

  always_comb begin
    // window start discards the running window
    pos_c  = start_reg ? '0 : position;
    prev_c = start_reg ? '0 : previous_plain;
    term_c = start_reg ? 1'b0 : terminated;
    rej_c  = start_reg ? 1'b0 : rejected;
    run_c  = start_reg ? CNT_W'(CHECK_BYTES) : check_run;
    vow_c  = start_reg ? '0 : vowel_count;
    cyr_c  = start_reg ? '0 : cyrillic_count;
    big_c  = start_reg ? 1'b0 : bigram_seen;
    len_c  = start_reg ? '0 : length_so_far;

    key_byte = key_value[{pos_c[2:0], 3'b000} +: 8];
    tmp      = cipher_reg ^ (key_byte + 8'(pos_c >> 3));
    v        = (pos_c == '0) ? tmp : tmp + prev_c;
    in_check = pos_c < POS_W'(CHECK_BYTES);

    previous_plain_next = prev_c;
    terminated_next     = term_c;
    rejected_next       = rej_c;
    check_run_next      = run_c;
    vowel_count_next    = vow_c;
    cyrillic_count_next = cyr_c;
    bigram_seen_next    = big_c;
    length_so_far_next  = len_c;
    text_c              = 1'b0;
    plain_c             = '0;

    if (!term_c) begin
      if (v == '0) begin
        terminated_next = 1'b1;
        if (in_check) begin
          check_run_next = CNT_W'(pos_c);
        end
      end else if (!is_allowed(v)) begin
        terminated_next = 1'b1;
        if (in_check) begin
          rejected_next = 1'b1;
        end
      end else begin
        text_c  = 1'b1;
        plain_c = v;
        if (in_check) begin
          vowel_count_next    = vow_c + CNT_W'(vowel_letter(v));
          cyrillic_count_next = cyr_c + CNT_W'(is_cyrillic(v));
          if (pos_c != '0 && is_bigram({prev_c, v})) begin
            bigram_seen_next = 1'b1;
          end
        end
        previous_plain_next = v;
        length_so_far_next  = len_c + 1'b1;
      end
    end

    done_c = pos_c == POS_W'(WINDOW_BYTES - 1);

    // last byte lies past the check span, so the verdict uses the held counts;
    // floor(100*v/r) < lo  <=>  100*v < lo*r,  > hi  <=>  100*v >= (hi+1)*r
    vowel_scaled = PROD_W'(vow_c) * PCT_SCALE;
    low_bound    = PROD_W'(vowel_low_pct) * PROD_W'(run_c);
    high_bound   = (PROD_W'(vowel_high_pct) + 1'b1) * PROD_W'(run_c);
    hit_c = done_c && !rej_c && (run_c >= min_run) && (cyr_c >= min_cyrillic)
            && (run_c != '0) && big_c
            && !(vowel_scaled < low_bound) && !(vowel_scaled >= high_bound);

    len_out = (length_so_far_next > LEN_W'(LEN_MAX)) ? LEN_MAX
                                                     : LEN_OUT_W'(length_so_far_next);

    position_next = pos_c + 1'b1;
    if (done_c) begin
      position_next       = '0;
      previous_plain_next = '0;
      terminated_next     = 1'b0;
      rejected_next       = 1'b0;
      check_run_next      = CNT_W'(CHECK_BYTES);
      vowel_count_next    = '0;
      cyrillic_count_next = '0;
      bigram_seen_next    = 1'b0;
      length_so_far_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      previous_plain <= '0;
      terminated     <= 1'b0;
      rejected       <= 1'b0;
      check_run      <= CNT_W'(CHECK_BYTES);
      vowel_count    <= '0;
      cyrillic_count <= '0;
      bigram_seen    <= 1'b0;
      length_so_far  <= '0;
    end else if (cmd.step) begin
      position       <= position_next;
      previous_plain <= previous_plain_next;
      terminated     <= terminated_next;
      rejected       <= rejected_next;
      check_run      <= check_run_next;
      vowel_count    <= vowel_count_next;
      cyrillic_count <= cyrillic_count_next;
      bigram_seen    <= bigram_seen_next;
      length_so_far  <= length_so_far_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_plain <= plain_c;
      out_index <= IDX_OUT_W'(pos_c);
      out_text  <= text_c;
      out_done  <= done_c;
      out_hit   <= hit_c;
      out_len   <= done_c ? len_out : '0;
    end
  end

endmodule

// ----- sv/chained_xor_decrypt_text_filter.sv -----
// Top level of the chained XOR decrypt and text filter.
// One ciphertext byte per input transaction, one result per byte. Each byte
// is registered, then decoded as the window statistics are updated; the next
// byte is taken only after that. Decoding waits while the output register
// holds an untaken result, and the input is held off until it goes, though
// one byte can be taken in while the result before it still waits. A window
// is 64 bytes; tlast marks its last result, which carries the verdict and the
// text length. No clearing pass is needed after reset. Configuration must
// be written only while no byte is in flight; the block does not enforce it.
`include "chained_xor_decrypt_text_filter_macros.svh"

module chained_xor_decrypt_text_filter
  import cxdtf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] cipher_byte
  input  logic                 s_tuser,   // [0] window_start
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,   // [7:0] plain_byte, [13:8] byte_index,
                                          // [20:14] text_length, [23:21] zero
  output logic [USER_W-1:0]    m_tuser,   // [0] in_text, [1] hit
  output logic                 m_tlast,   // window_done
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data
);

  cmd_t                 cmd;
  logic [7:0]           plain_byte;
  logic [IDX_OUT_W-1:0] byte_index;
  logic                 in_text, window_done, hit;
  logic [LEN_OUT_W-1:0] text_length;

  cxdtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  cxdtf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_cipher (s_tdata),
    .in_start  (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_plain (plain_byte),
    .out_index (byte_index),
    .out_text  (in_text),
    .out_done  (window_done),
    .out_hit   (hit),
    .out_len   (text_length)
  );

  assign m_tdata = {(DATA_W - 8 - IDX_OUT_W - LEN_OUT_W)'(0), text_length, byte_index,
                    plain_byte};
  assign m_tuser = {hit, in_text};
  assign m_tlast = window_done;

  `CXDTF_ASSERT(a_step_gives_result, cmd.step |=> m_tvalid, "decode step lost its result")
  `CXDTF_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready,
    "second byte taken before decode")
  `CXDTF_ASSERT(a_last_at_window_end,
    (m_tvalid && m_tlast) |-> (byte_index == IDX_OUT_W'(WINDOW_BYTES - 1)),
    "window end flagged at wrong position")
  `CXDTF_NEVER(a_hit_only_at_end, m_tvalid && hit && !window_done,
    "verdict outside window end")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the chained XOR decrypt text filter.
`timescale 1ns / 1ps

module tb_top
  import cxdtf_pkg::*;
;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 500;
  localparam int HOLD_CYCLES  = 100;

  typedef struct packed {
    logic [7:0] cipher;
    logic       start;
  } cipher_item_t;

  typedef struct packed {
    logic [7:0]           plain;
    logic [IDX_OUT_W-1:0] idx;
    logic                 in_text;
    logic                 done;
    logic                 hit;
    logic [LEN_OUT_W-1:0] len;
  } decoded_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [DATA_W-1:0]    m_tdata;
  logic [USER_W-1:0]    m_tuser;
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_data = '0;

  chained_xor_decrypt_text_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  logic [7:0] vowel_set [20] = '{
    8'hc1, 8'hc5, 8'hc9, 8'hcf, 8'hd5, 8'hd9, 8'hc0, 8'hd1, 8'hc7,
    8'he1, 8'he5, 8'he9, 8'hef, 8'hf5, 8'hf9, 8'he0, 8'hf1, 8'he7,
    8'ha3, 8'hb3
  };

  logic [15:0] pair_set [40] = '{
    16'hd4d3, 16'hcfd4, 16'hd8d4, 16'hc1ce, 16'hc1d2, 16'hcfd0, 16'hd2d0, 16'hd7cf,
    16'hc7cf, 16'hced1, 16'hcbd3, 16'hd4c1, 16'hdec1, 16'hd2c5, 16'hc1d7, 16'hc9cc,
    16'hcfce, 16'hc5ce, 16'hcdcf, 16'hc5cd, 16'hd0cf, 16'hcbcf, 16'hc5cb, 16'hc1cc,
    16'hcdce, 16'hcec5, 16'hc1cd, 16'hcfcd, 16'hd1cd, 16'hefd4, 16'hefd1, 16'heed5,
    16'hefce, 16'hf3cf, 16'hf2c1, 16'hf4cf, 16'hc1d4, 16'hc9d3, 16'hcfd2, 16'hd0d2
  };

  // decoder state mirror
  logic [KEY_W-1:0] key_reg;
  logic [CNT_W-1:0] min_run_reg, min_cyr_reg;
  logic [PCT_W-1:0] vowel_lo_reg, vowel_hi_reg;
  int               win_pos, span_run, vowel_cnt, cyr_cnt, text_len;
  logic [7:0]       prev_plain;
  logic             stopped, rejected_span, pair_hit;

  cipher_item_t cipher_q [$];
  decoded_t     decoded_q [$];
  logic [7:0]   text_buf [$];
  logic [KEY_W-1:0] enc_key = '0;

  int n_errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_windows = 0;
  int n_hits = 0;
  int n_phases = 0;
  int cycle_cnt = 0;

  function automatic logic in_vowels(input logic [7:0] b);
    for (int k = 0; k < 20; k++)
      if (vowel_set[k] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic in_pairs(input logic [15:0] p);
    for (int k = 0; k < 40; k++)
      if (pair_set[k] == p) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_window();
    win_pos       = 0;
    prev_plain    = '0;
    stopped       = 1'b0;
    rejected_span = 1'b0;
    span_run      = CHECK_BYTES;
    vowel_cnt     = 0;
    cyr_cnt       = 0;
    pair_hit      = 1'b0;
    text_len      = 0;
  endfunction

  function automatic decoded_t decrypt_and_score(input logic [7:0] c, input logic start);
    decoded_t   r;
    logic [7:0] kb, blk, v;
    logic       cyr, ok;
    int         pct;
    r = '0;
    if (start) clear_window();
    blk = 8'(win_pos / 8);
    kb  = key_reg[(win_pos % 8) * 8 +: 8] + blk;
    v   = c ^ kb;
    if (win_pos != 0) v = v + prev_plain;
    cyr = (v >= 8'hc0) && (v != 8'hff);
    r.idx = win_pos[IDX_OUT_W-1:0];
    if (!stopped) begin
      if (v == 8'h00) begin
        stopped = 1'b1;
        if (win_pos < CHECK_BYTES) span_run = win_pos;
      end else if (!(cyr || (v >= 8'h20 && v < 8'h7f))) begin
        stopped = 1'b1;
        if (win_pos < CHECK_BYTES) rejected_span = 1'b1;
      end else begin
        r.in_text = 1'b1;
        r.plain   = v;
        if (win_pos < CHECK_BYTES) begin
          if (in_vowels(v)) vowel_cnt++;
          if (cyr) cyr_cnt++;
          if (win_pos > 0 && in_pairs({prev_plain, v})) pair_hit = 1'b1;
        end
        prev_plain = v;
        text_len++;
      end
    end
    if (win_pos >= WINDOW_BYTES - 1) begin
      pct = (span_run > 0) ? (vowel_cnt * 100) / span_run : 0;
      ok  = !rejected_span && span_run >= min_run_reg && cyr_cnt >= min_cyr_reg &&
            span_run > 0 && pair_hit && pct >= vowel_lo_reg && pct <= vowel_hi_reg;
      r.done = 1'b1;
      r.hit  = ok;
      r.len  = (text_len > 127) ? 7'd127 : text_len[LEN_OUT_W-1:0];
      clear_window();
    end else begin
      win_pos++;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned e, input int unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      n_errors++;
    end
  endtask

  // Predictor and result monitor
  logic s_fire = 1'b0;

  always @(posedge clk) begin
    decoded_t e;
    if (rst) begin
      key_reg      <= '0;
      min_run_reg  <= MIN_RUN_RST;
      min_cyr_reg  <= MIN_CYR_RST;
      vowel_lo_reg <= VOWEL_LO_RST;
      vowel_hi_reg <= VOWEL_HI_RST;
      clear_window();
      s_fire <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY:      key_reg      <= cfg_data;
          REG_MIN_RUN:  min_run_reg  <= cfg_data[CNT_W-1:0];
          REG_MIN_CYR:  min_cyr_reg  <= cfg_data[CNT_W-1:0];
          REG_VOWEL_LO: vowel_lo_reg <= cfg_data[PCT_W-1:0];
          REG_VOWEL_HI: vowel_hi_reg <= cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        n_out++;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, actual tdata %h tuser %h tlast %b",
                   $time, m_tdata, m_tuser, m_tlast);
          n_errors++;
        end else begin
          e = decoded_q.pop_front();
          check_field("plain_byte", e.plain, m_tdata[7:0]);
          check_field("byte_index", e.idx, m_tdata[13:8]);
          check_field("text_length", e.len, m_tdata[20:14]);
          check_field("tdata pad", 0, m_tdata[23:21]);
          check_field("in_text", e.in_text, m_tuser[0]);
          check_field("hit", e.hit, m_tuser[1]);
          check_field("window_done", e.done, m_tlast);
        end
        if (m_tlast) begin
          n_windows++;
          if (m_tuser[1]) n_hits++;
        end
      end
      s_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        n_in++;
        decoded_q.push_back(decrypt_and_score(s_tdata, s_tuser));
      end
    end
  end

  // Byte driver: bursts with random gaps
  int           burst_left = 0;
  int           gap_left = 0;
  cipher_item_t drv_item;

  always @(negedge clk) begin
    if (!rst && (!s_tvalid || s_fire)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (cipher_q.size() > 0) begin
        drv_item = cipher_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= drv_item.cipher;
        s_tuser  <= drv_item.start;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: changing stall pattern plus two long hold-offs
  int rx_mode = 0;
  int rx_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  logic rx_toggle = 1'b0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (holds_done < 2 && n_out >= (holds_done == 0 ? 150 : 400) &&
                 cipher_q.size() > 0) begin
      holds_done++;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(10, 60);
      end else begin
        rx_left = rx_left - 1;
      end
      rx_toggle = ~rx_toggle;
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 1) == 1);
        2:       m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= rx_toggle;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, decoded_q.size());
      $display("** chained_xor_decrypt_text_filter: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
    if (idx == REG_KEY) enc_key = val;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_idle();
    while (!(cipher_q.size() == 0 && !s_tvalid && decoded_q.size() == 0)) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_settings(input int p);
    logic [KEY_W-1:0] key, mr, mc, lo, hi;
    key = {$urandom, $urandom};
    case (p)
      0: begin mr = 5;  mc = 3;  lo = 20;  hi = 65;  end
      1: begin key = '0; mr = 0; mc = 0; lo = 0; hi = 100; end
      2: begin key = '1; mr = 12; mc = 12; lo = 100; hi = 100; end
      3: begin mr = 15; mc = 15; lo = 127; hi = 127; end
      4: begin mr = 1;  mc = 0;  lo = 0;   hi = 0;   end
      default:
        if ($urandom_range(0, 4) == 0) begin
          mr = {$urandom, $urandom};
          mc = {$urandom, $urandom};
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end else begin
          mr = $urandom_range(0, CHECK_BYTES);
          mc = $urandom_range(0, 6);
          lo = $urandom_range(0, 35);
          hi = $urandom_range(45, 100);
        end
    endcase
    write_reg(REG_KEY, key);
    write_reg(REG_MIN_RUN, mr);
    write_reg(REG_MIN_CYR, mc);
    write_reg(REG_VOWEL_LO, lo);
    write_reg(REG_VOWEL_HI, hi);
    n_phases++;
  endtask

  task automatic push_raw(input logic [7:0] c, input logic start);
    cipher_q.push_back({c, start});
  endtask

  // encrypt text_buf from window position 0 under the current key
  task automatic emit_text(input logic start);
    logic [7:0] prev, kb, blk, c;
    prev = '0;
    for (int k = 0; k < text_buf.size(); k++) begin
      blk = 8'(k / 8);
      kb  = enc_key[(k % 8) * 8 +: 8] + blk;
      c   = (text_buf[k] - prev) ^ kb;
      prev = text_buf[k];
      push_raw(c, (k == 0) ? start : 1'b0);
    end
    text_buf.delete();
  endtask

  function automatic logic [7:0] bad_byte();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(1, 'h1f));
      1:       return 8'($urandom_range('h7f, 'hbf));
      default: return 8'hff;
    endcase
  endfunction

  task automatic build_window(input int n_bytes, input logic start);
    logic [15:0] pair;
    int          stop_pos, mix;
    text_buf.delete();
    for (int k = 0; k < WINDOW_BYTES; k++) begin
      if (k < CHECK_BYTES && $urandom_range(0, 7) != 0)
        text_buf.push_back(8'($urandom_range('hc0, 'hdf)));
      else if ($urandom_range(0, 1))
        text_buf.push_back(8'($urandom_range('h20, 'h7e)));
      else
        text_buf.push_back(8'($urandom_range('hc0, 'hfe)));
    end
    mix = $urandom_range(0, 5);
    for (int k = 0; k < CHECK_BYTES; k++) begin
      if (mix == 0) text_buf[k] = vowel_set[$urandom_range(0, 17)];
      else if (mix == 1 && in_vowels(text_buf[k])) text_buf[k] = 8'hd4;
    end
    if ($urandom_range(0, 3) != 0) begin
      pair     = pair_set[$urandom_range(0, 39)];
      stop_pos = $urandom_range(0, CHECK_BYTES - 2);
      text_buf[stop_pos]     = pair[15:8];
      text_buf[stop_pos + 1] = pair[7:0];
    end
    case ($urandom_range(0, 2))
      1: begin
        stop_pos = $urandom_range(0, 1) ? $urandom_range(0, CHECK_BYTES - 1)
                                        : $urandom_range(CHECK_BYTES, WINDOW_BYTES - 1);
        text_buf[stop_pos] = 8'h00;
      end
      2: begin
        stop_pos = $urandom_range(0, 1) ? $urandom_range(0, CHECK_BYTES - 1)
                                        : $urandom_range(CHECK_BYTES, WINDOW_BYTES - 1);
        text_buf[stop_pos] = bad_byte();
      end
      default: ;
    endcase
    while (text_buf.size() > n_bytes) void'(text_buf.pop_back());
    emit_text(start);
  endtask

  initial begin
    int   n_random, len, roll, phase_windows, p;
    logic need_start;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero at the first position, then a byte after termination
    text_buf.push_back(8'h00);
    emit_text(1'b1);
    push_raw(8'hff, 1'b0);
    // restart mid-window: printable and Cyrillic limits, then a control byte
    text_buf.push_back(8'h7e);
    text_buf.push_back(8'h20);
    text_buf.push_back(8'hc0);
    text_buf.push_back(8'hfe);
    text_buf.push_back(8'h1f);
    emit_text(1'b1);
    text_buf.push_back(8'hd4);
    text_buf.push_back(8'hd3);
    text_buf.push_back(8'h7f);
    emit_text(1'b1);
    text_buf.push_back(8'hff);
    emit_text(1'b1);
    push_raw(8'h00, 1'b1);
    push_raw(8'hff, 1'b1);
    push_raw(8'ha5, 1'b0);
    push_raw(8'h5a, 1'b0);

    n_random      = 0;
    phase_windows = 1;
    p             = 0;
    need_start    = 1'b1;
    while (n_random < RANDOM_BYTES) begin
      if (phase_windows >= 1) begin
        wait_idle();
        load_settings(p);
        p++;
        phase_windows = 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        build_window(WINDOW_BYTES, need_start | ($urandom_range(0, 1) == 1));
        need_start = 1'b0;
        n_random += WINDOW_BYTES;
        phase_windows++;
      end else if (roll < 87) begin
        len = $urandom_range(1, WINDOW_BYTES - 1);
        build_window(len, 1'b1);
        need_start = 1'b1;
        n_random += len;
      end else begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          push_raw(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        need_start = 1'b1;
        n_random += len;
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);
    $display("Run covered %0d bytes in and %0d results out, %0d windows closed, %0d hits",
             n_in, n_out, n_windows, n_hits);
    $display("across %0d register settings including limits and out-of-range thresholds",
             n_phases);
    if (n_errors == 0)
      $display("** chained_xor_decrypt_text_filter: PASSED **");
    else
      $display("** chained_xor_decrypt_text_filter: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/cxdtf_pkg.sv
sv/cxdtf_ctrl.sv
sv/cxdtf_dp.sv
sv/chained_xor_decrypt_text_filter.sv
tb/tb_top.sv
